// ===== design/asbm_pkg.sv =====
// Shared types, codes and sizes for the alarm slot bank matcher.
package asbm_pkg;

  localparam int ALARM_SLOTS = 8;
  localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  // Wide enough for a slot number, the 3-bit slot field and the value 8.
  localparam int CMP_W = ((IDX_W > 3) ? IDX_W : 3) + 1;
  localparam int MASK_W = 8;

  typedef enum logic [1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_UNREGISTER = 2'd1,
    ACT_TICK       = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_REG = 2'd2
  } result_code_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  slot;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        repeat_mode;
    logic [6:0]  weekday_mask;
    logic        armed;
    logic [2:0]  weekday;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        slot_given;
    logic [MASK_W-1:0] fired_mask;
  } out_item_t;

  // Travels down the cell chain with one command and collects its outcome.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  given;
    logic              hit;
    logic [MASK_W-1:0] fired;
  } tok_t;

endpackage

// ===== design/asbm_ifs.sv =====
// Valid/ready channel interfaces for the input and result beats.
interface asbm_in_if
  import asbm_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface asbm_out_if
  import asbm_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/asbm_cell.sv =====
// One alarm slot: holds its alarm and updates the passing command token.
module asbm_cell
  import asbm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  in_item_t         cmd,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic        used_r, used_nxt;
  logic        armed_r, armed_nxt;
  logic        wr_en;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic        repeat_r;
  logic [6:0]  days_r;
  tok_t        tok_r, tok_nxt;

  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] slot_ext;
  logic [7:0]       days_ext;
  logic             time_match;
  logic             fire;
  logic             disarm;

  assign idx_ext  = CMP_W'(cell_idx);
  assign slot_ext = CMP_W'(cmd.slot);
  assign days_ext = {1'b0, days_r};
  assign time_match = used_r && armed_r && (hour_r == cmd.hour) && (minute_r == cmd.minute);

  always_comb begin
    fire   = 1'b0;
    disarm = 1'b0;
    if (time_match) begin
      if (year_r != 12'd0) begin
        if ((year_r == cmd.year) && (month_r == cmd.month) && (day_r == cmd.day)) begin
          fire   = 1'b1;
          disarm = 1'b1;
        end
      end else if (!repeat_r) begin
        fire   = 1'b1;
        disarm = 1'b1;
      end else begin
        // Weekday seven lands on the padding bit and never matches.
        fire = days_ext[cmd.weekday];
      end
    end
  end

  always_comb begin
    tok_nxt   = tok_i;
    used_nxt  = used_r;
    armed_nxt = armed_r;
    wr_en     = 1'b0;
    if (tok_i.valid) begin
      unique case (cmd.action)
        ACT_REGISTER: begin
          if (!tok_i.found && !used_r) begin
            used_nxt      = 1'b1;
            armed_nxt     = cmd.armed;
            wr_en         = 1'b1;
            tok_nxt.found = 1'b1;
            tok_nxt.given = cell_idx;
          end
        end
        ACT_UNREGISTER: begin
          if ((slot_ext == idx_ext) && used_r) begin
            used_nxt    = 1'b0;
            armed_nxt   = 1'b0;
            tok_nxt.hit = 1'b1;
          end
        end
        ACT_TICK: begin
          if (fire) begin
            if (disarm) begin
              armed_nxt = 1'b0;
            end
            if (idx_ext < CMP_W'(MASK_W)) begin
              tok_nxt.fired[idx_ext[2:0]] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      armed_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      used_r  <= used_nxt;
      armed_r <= armed_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hour_r   <= cmd.hour;
      minute_r <= cmd.minute;
      year_r   <= cmd.year;
      month_r  <= cmd.month;
      day_r    <= cmd.day;
      repeat_r <= cmd.repeat_mode;
      days_r   <= cmd.weekday_mask;
    end
  end

  assign tok_o = tok_r;

`ifndef SYNTHESIS
  // An armed slot is always a used slot.
  a_armed_used: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> used_r) else $error("armed slot is not in use");

  // A register command is claimed by at most one cell on its way down.
  a_single_claim: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_i.valid && tok_i.found) |=> !$rose(used_r))
    else $error("slot claimed after an earlier cell took the command");

  // Only a command passing this cell can change its slot state.
  a_quiet_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !tok_i.valid |=> ($stable(used_r) && $stable(armed_r)))
    else $error("slot state changed with no command present");
`endif

endmodule

// ===== design/alarm_slot_bank_matcher_core.sv =====
// Top level: command register, chain of alarm slot cells and result register.
//
// Usage: items arrive on in_ch (valid/ready), one result beat per item leaves
// on out_ch. An item registers an alarm in the lowest free slot, frees a slot,
// or carries a minute tick that is checked against every armed slot.
// The accepted command is held in a register while a token walks down a row
// of ALARM_SLOTS cells, one cell per cycle; each cell owns one slot and
// updates the token with what it did (slot taken, slot freed, slot fired).
// The result beat is registered: after the input beat is accepted, the token
// passes the start register, each cell's token register and the result
// register before it shows. The block works on one item at a time and takes
// no new item until the result of the last one has been accepted.
// in_ch.ready is high only when no item is in flight. If the receiver stalls,
// the result stays in the output register and no new beat is taken until it
// is accepted. Reset (rst_n low, synchronous) frees and disarms every slot
// and drops any beat in flight; the stored alarm times need no reset.
module alarm_slot_bank_matcher_core
  import asbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  asbm_in_if.sink     in_ch,
  asbm_out_if.source  out_ch
);

  logic      busy_r, busy_nxt;
  logic      start_r, start_nxt;
  logic      out_valid_r, out_valid_nxt;
  in_item_t  cmd_r;
  out_item_t out_r, out_nxt;
  logic      in_fire;
  logic      out_fire;
  tok_t      tok_w [ALARM_SLOTS+1];
  tok_t      tok_end;
  logic [CMP_W-1:0] given_ext;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  assign in_ch.ready  = !busy_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].valid = start_r;
  end

  for (genvar i = 0; i < ALARM_SLOTS; i++) begin : g_cell
    asbm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .cmd      (cmd_r),
      .tok_i    (tok_w[i]),
      .tok_o    (tok_w[i+1])
    );
  end

  assign tok_end   = tok_w[ALARM_SLOTS];
  assign given_ext = CMP_W'(tok_end.given);

  always_comb begin
    out_nxt = '0;
    unique case (cmd_r.action)
      ACT_REGISTER: begin
        if (tok_end.found) begin
          out_nxt.slot_given = given_ext[2:0];
        end else begin
          out_nxt.status = ST_FULL;
        end
      end
      ACT_UNREGISTER: begin
        if (!tok_end.hit) begin
          out_nxt.status = ST_NOT_REG;
        end
      end
      ACT_TICK: begin
        out_nxt.fired_mask = tok_end.fired;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    start_nxt     = in_fire;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end
    if (tok_end.valid) begin
      out_valid_nxt = 1'b1;
    end
    if (out_fire) begin
      out_valid_nxt = 1'b0;
      busy_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_ch.data;
    end
    if (tok_end.valid) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  // A result beat only exists while its item still holds the block.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r) else $error("result valid with no item in flight");

  // A started token always reaches the end of the chain, through every cell register.
  a_token_time: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> ##(ALARM_SLOTS) tok_end.valid)
    else $error("token did not reach the chain end on time");

  // A new token never starts while a result is still waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !out_valid_r) else $error("new item started over a pending result");

  // Once a result is taken the block is free for the next beat.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> (in_ch.ready && !out_valid_r))
    else $error("block not released after the result beat");
`endif

endmodule
